@@ rtl/core/hesd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Hex escape stream decoder package
// Character codes, queue sizing and the bundle type passed from the front
// to the back of the decoder.
// ---------------------------------------------------------------------------
package hesd_pkg;

  localparam logic [7:0] CH_PCT  = 8'h25;
  localparam logic [7:0] CH_BSL  = 8'h5C;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_LX   = 8'h78;
  localparam logic [7:0] CH_UX   = 8'h58;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_DOT  = 8'h2E;

  localparam int HESD_QUEUE_DEPTH = 2;

  // All results caused by one input item.
  typedef struct packed {
    logic [2:0]      cnt;
    logic [3:0][7:0] bytes;
    logic            has_byte;
    logic            eol;
  } hesd_bundle_t;

endpackage
`default_nettype wire

@@ rtl/core/hesd_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Hex escape stream decoder channels
// Valid/ready channels for input characters and decoded results.
// ---------------------------------------------------------------------------
interface hesd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_line;

  modport source (output valid, output in_byte, output end_of_line, input ready);
  modport sink (input valid, input in_byte, input end_of_line, output ready);
endinterface

interface hesd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       has_byte;
  logic       last;

  modport source (output valid, output out_byte, output has_byte, output last,
                  input ready);
  modport sink (input valid, input out_byte, input has_byte, input last,
                output ready);
endinterface
`default_nettype wire

@@ rtl/core/hesd_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Hex escape stream decoder front
// Accepts characters, matches escapes against the pending buffer and hands
// every result of one item to the queue as a single bundle.
// ---------------------------------------------------------------------------
module hesd_front (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  hesd_in_if.sink                    in_ch,
  input  wire logic                  q_full,
  output logic                       push,
  output hesd_pkg::hesd_bundle_t     push_bundle
);
  import hesd_pkg::*;

  localparam logic [1:0] M_NONE  = 2'd0;
  localparam logic [1:0] M_WAIT  = 2'd1;
  localparam logic [1:0] M_LONG  = 2'd2;
  localparam logic [1:0] M_SHORT = 2'd3;

  function automatic logic is_hex(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
           (c >= 8'h61 && c <= 8'h66);
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    return c[6] ? c[3:0] + 4'd9 : c[3:0];
  endfunction

  function automatic logic [1:0] classify(input logic [7:0] c0, input logic [7:0] c1,
                                          input logic [7:0] c2, input logic [7:0] c3,
                                          input logic [2:0] len);
    logic [1:0] m;
    m = M_NONE;
    if (c0 == CH_BSL || c0 == CH_ZERO) begin
      if (len < 3'd2) m = M_WAIT;
      else if (c1 != CH_LX && c1 != CH_UX) m = M_NONE;
      else if (len < 3'd3) m = M_WAIT;
      else if (!is_hex(c2)) m = M_NONE;
      else if (len < 3'd4) m = M_WAIT;
      else if (!is_hex(c3)) m = M_NONE;
      else m = M_LONG;
    end else if (c0 == CH_PCT) begin
      if (len < 3'd2) m = M_WAIT;
      else if (!is_hex(c1)) m = M_NONE;
      else if (len < 3'd3) m = M_WAIT;
      else if (!is_hex(c2)) m = M_NONE;
      else m = M_SHORT;
    end
    return m;
  endfunction

  logic [7:0]      pend_r [3];
  logic [7:0]      pend_nxt [3];
  logic [1:0]      pcnt_r, pcnt_nxt;
  logic [7:0]      buf_w [4];
  logic [2:0]      n_w, start_v, len_v, k_v;
  logic            stop_v, eol, acc;
  logic [7:0]      p0, p1, p2, p3;
  logic [1:0]      m_v;
  logic [3:0][7:0] res_w;

  assign eol = in_ch.end_of_line;
  assign in_ch.ready = !q_full;
  assign acc = in_ch.valid && !q_full;

  always_comb begin
    for (int i = 0; i < 3; i++) buf_w[i] = pend_r[i];
    buf_w[3] = 8'h00;
    buf_w[pcnt_r] = in_ch.in_byte;
    n_w = {1'b0, pcnt_r} + 3'd1;
    start_v = '0;
    stop_v = 1'b0;
    k_v = '0;
    res_w = '0;
    len_v = '0;
    p0 = '0;
    p1 = '0;
    p2 = '0;
    p3 = '0;
    m_v = M_NONE;
    for (int it = 0; it < 4; it++) begin
      if (!stop_v && start_v < n_w) begin
        len_v = n_w - start_v;
        p0 = buf_w[start_v[1:0]];
        p1 = buf_w[start_v[1:0] + 2'd1];
        p2 = buf_w[start_v[1:0] + 2'd2];
        p3 = buf_w[start_v[1:0] + 2'd3];
        m_v = classify(p0, p1, p2, p3, len_v);
        if (m_v == M_WAIT && !eol) begin
          stop_v = 1'b1;
        end else if (m_v == M_LONG) begin
          res_w[k_v[1:0]] = {hex_val(p2), hex_val(p3)};
          k_v = k_v + 3'd1;
          start_v = start_v + 3'd4;
        end else if (m_v == M_SHORT) begin
          res_w[k_v[1:0]] = {hex_val(p1), hex_val(p2)};
          k_v = k_v + 3'd1;
          start_v = start_v + 3'd3;
        end else begin
          if (p0 != CH_CR && p0 != CH_LF) begin
            res_w[k_v[1:0]] = CH_DOT;
            k_v = k_v + 3'd1;
          end
          start_v = start_v + 3'd1;
        end
      end
    end
    for (int i = 0; i < 3; i++) pend_nxt[i] = buf_w[start_v[1:0] + 2'(i)];
    pcnt_nxt = 2'(n_w - start_v);
  end

  always_comb begin
    push_bundle.cnt      = (k_v == 3'd0) ? 3'd1 : k_v;
    push_bundle.bytes    = res_w;
    push_bundle.has_byte = (k_v != 3'd0);
    push_bundle.eol      = eol;
    push = acc && (k_v != 3'd0 || eol);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pcnt_r <= '0;
    end else if (acc) begin
      pcnt_r <= pcnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      for (int i = 0; i < 3; i++) pend_r[i] <= pend_nxt[i];
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/hesd_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Hex escape stream decoder queue
// Short first-in first-out queue of result bundles between front and back.
// ---------------------------------------------------------------------------
module hesd_queue #(
  parameter int DEPTH = hesd_pkg::HESD_QUEUE_DEPTH
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   push,
  input  wire hesd_pkg::hesd_bundle_t push_bundle,
  output logic                        full,
  input  wire logic                   pop,
  output hesd_pkg::hesd_bundle_t      head,
  output logic                        empty
);
  import hesd_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  hesd_bundle_t  mem_r [DEPTH];
  logic [PW-1:0] wptr_r, rptr_r;
  logic [CW-1:0] cnt_r;

  assign full  = (cnt_r == CW'(DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_bundle;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) begin
        wptr_r <= (wptr_r == PW'(DEPTH - 1)) ? '0 : wptr_r + 1'b1;
      end
      if (pop) begin
        rptr_r <= (rptr_r == PW'(DEPTH - 1)) ? '0 : rptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/hesd_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Hex escape stream decoder back
// Walks through the bundle at the head of the queue and delivers its
// results one item at a time.
// ---------------------------------------------------------------------------
module hesd_back (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire hesd_pkg::hesd_bundle_t head,
  input  wire logic                   empty,
  output logic                        pop,
  hesd_out_if.source                  out_ch
);
  import hesd_pkg::*;

  logic [1:0] idx_r;
  logic       final_res, take;

  assign final_res = (idx_r == 2'(head.cnt - 3'd1));
  assign take      = out_ch.valid && out_ch.ready;
  assign pop       = take && final_res;

  assign out_ch.valid    = !empty;
  assign out_ch.out_byte = head.bytes[idx_r];
  assign out_ch.has_byte = head.has_byte;
  assign out_ch.last     = head.eol && final_res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else if (take) begin
      idx_r <= final_res ? 2'd0 : idx_r + 2'd1;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/hex_escape_stream_decoder.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Hex escape stream decoder
// Decodes backslash-x, 0x and percent hex escapes in a character stream.
// ---------------------------------------------------------------------------
// Channel  Direction  Payload
// in_ch    sink       in_byte[7:0], end_of_line
// out_ch   source     out_byte[7:0], has_byte, last
//
// One input item is accepted per cycle while the queue has room.
// An item that causes n results occupies the output for n transfers; the
// queue holds QUEUE_DEPTH bundles so the front keeps going meanwhile.
// Reset is synchronous and clears the pending count, queue and result index.
// A stalled output fills the queue and then stalls the input.
// ---------------------------------------------------------------------------
module hex_escape_stream_decoder #(
  parameter int QUEUE_DEPTH = hesd_pkg::HESD_QUEUE_DEPTH
) (
  input wire logic   clk,
  input wire logic   rst_n,
  hesd_in_if.sink    in_ch,
  hesd_out_if.source out_ch
);
  import hesd_pkg::*;

  hesd_bundle_t push_bundle, head;
  logic         push, pop, q_full, q_empty;

  hesd_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .q_full      (q_full),
    .push        (push),
    .push_bundle (push_bundle)
  );

  hesd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (push),
    .push_bundle (push_bundle),
    .full        (q_full),
    .pop         (pop),
    .head        (head),
    .empty       (q_empty)
  );

  hesd_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (head),
    .empty  (q_empty),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule
`default_nettype wire
